### rtl/core/spd_pkg.sv
// Shared types, result codes and a helper function for the sensor packet deframer.
package spd_pkg;

  localparam int SENSOR_CHANNELS = 8;
  localparam int RES_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_DIN     = 3'd1,
    KIND_ECHO    = 3'd2,
    KIND_OVERRUN = 3'd3,
    KIND_SAMPLE  = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_DIN  = 7'b0000010,
    PH_DOUT = 7'b0000100,
    PH_OVR  = 7'b0001000,
    PH_CNT  = 7'b0010000,
    PH_HOLD = 7'b0100000,
    PH_EMIT = 7'b1000000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  channel;
    logic [11:0] value;
    logic [3:0]  sample_index;
    logic        packet_lost;
    logic        overcurrent;
    logic        ratiometric;
    logic        last;
  } result_t;

  // Lowest channel at or above 'from' whose flag is set; bit 3 set means none.
  function automatic logic [3:0] pick_from(input logic [SENSOR_CHANNELS-1:0] gt,
                                           input logic [3:0] from);
    logic [3:0] sel;
    sel = 4'd8;
    for (int c = SENSOR_CHANNELS - 1; c >= 0; c--) begin
      if (gt[c] && (4'(c) >= from)) begin
        sel = 4'(c);
      end
    end
    return sel;
  endfunction

endpackage

### rtl/core/sensor_packet_deframer.sv
// Top level of the sensor packet deframer: byte parser and result queue.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------------
//  in_     | slave     | tdata: data_byte; tuser: start_of_packet
//  out_    | master    | tdata: channel, value, sample_index, packet_lost,
//          |           |        overcurrent, ratiometric; tuser: kind;
//          |           |        tlast: last result of the byte
//
// Each input beat is registered, decoded combinationally and its results
// written into a four-entry result queue, so a byte can be accepted every
// cycle unless the input stalls. An overrun byte, or the sample that closes
// the packet, yields two results, and the input stalls when the queue lacks
// room for two entries. The first result of a byte reaches the output
// through the input register and the result queue.
// Reset (rst_n low, synchronous) empties the queue and puts the parser idle,
// awaiting a header; a stall on the output never drops or repeats a result.
module sensor_packet_deframer
  import spd_pkg::*;
#(
  parameter int RES_DEPTH = RES_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] channel, [14:3] value, [18:15] sample_index,
                                  // [19] packet_lost, [20] overcurrent,
                                  // [21] ratiometric, [23:22] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last result caused by the byte
);

  // Input register.
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_sop_r;
  logic        fire;
  logic        room2;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [1:0]  cidx_r, cidx_nxt;
  logic [3:0]  cnt_r [SENSOR_CHANNELS];
  logic [3:0]  cnt_nxt [SENSOR_CHANNELS];
  logic [6:0]  left_r, left_nxt;
  logic [2:0]  cur_r, cur_nxt;
  logic [3:0]  round_r, round_nxt;
  logic        odd_r, odd_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  prev_r, prev_nxt;
  logic        seqv_r, seqv_nxt;

  // Per-byte results.
  result_t     res [2];
  logic [1:0]  res_n;
  logic [1:0]  push_n;
  result_t     q_data;

  logic [SENSOR_CHANNELS-1:0] gt_cur, gt_next;
  logic [3:0]  round_p1;
  logic [1:0]  ovr_k;

  assign fire      = in_valid_r && room2;
  assign in_tready = !in_valid_r || fire;
  assign round_p1  = round_r + 4'd1;

  // First set mask bit among the lower three, else the top one.
  assign ovr_k = mask_r[0] ? 2'd0 : (mask_r[1] ? 2'd1 : (mask_r[2] ? 2'd2 : 2'd3));

  always_comb begin
    for (int c = 0; c < SENSOR_CHANNELS; c++) begin
      gt_cur[c]  = (cnt_r[c] > round_r);
      gt_next[c] = (cnt_r[c] > round_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_sop_r  <= in_tuser;
    end
  end

  // Decode of the registered byte against the parser state.
  always_comb begin
    logic [SENSOR_CHANNELS-1:0] gt_new;
    logic [3:0]                 sel;
    logic [6:0]                 left_dec;
    logic [7:0]                 b;

    b         = in_byte_r;
    gt_new    = '0;
    sel       = '0;
    left_dec  = '0;
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    cidx_nxt  = cidx_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    cur_nxt   = cur_r;
    round_nxt = round_r;
    odd_nxt   = odd_r;
    held_nxt  = held_r;
    prev_nxt  = prev_r;
    seqv_nxt  = seqv_r;
    res[0]    = '0;
    res[1]    = '0;
    res_n     = 2'd0;

    if (in_sop_r) begin
      // A header always restarts the parser, whatever was in progress.
      res[0].kind        = KIND_STATUS;
      res[0].packet_lost = seqv_r && ((prev_r + 2'd1) != b[7:6]);
      res[0].overcurrent = b[5];
      res[0].ratiometric = b[4];
      res_n     = 2'd1;
      prev_nxt  = b[7:6];
      seqv_nxt  = 1'b1;
      mask_nxt  = b[3:0];
      cidx_nxt  = '0;
      left_nxt  = '0;
      cur_nxt   = '0;
      round_nxt = '0;
      odd_nxt   = 1'b0;
      phase_nxt = PH_DIN;
    end else begin
      case (phase_r)
        PH_DIN: begin
          res[0].kind  = KIND_DIN;
          res[0].value = {4'd0, ~b};
          res_n        = 2'd1;
          phase_nxt    = PH_DOUT;
        end
        PH_DOUT: begin
          res[0].kind  = KIND_ECHO;
          res[0].value = {4'd0, b};
          res_n        = 2'd1;
          phase_nxt    = (mask_r != '0) ? PH_OVR : PH_CNT;
        end
        PH_OVR: begin
          res[0].kind    = KIND_OVERRUN;
          res[0].channel = {ovr_k, 1'b0};
          res[0].value   = {8'd0, b[7:4]};
          res[1].kind    = KIND_OVERRUN;
          res[1].channel = {ovr_k, 1'b1};
          res[1].value   = {8'd0, b[3:0]};
          res_n          = 2'd2;
          mask_nxt       = mask_r & ~(4'd1 << ovr_k);
          if (mask_nxt == '0) begin
            phase_nxt = PH_CNT;
          end
        end
        PH_CNT: begin
          cnt_nxt[{cidx_r, 1'b0}] = b[7:4];
          cnt_nxt[{cidx_r, 1'b1}] = b[3:0];
          left_nxt = left_r + 7'(b[7:4]) + 7'(b[3:0]);
          cidx_nxt = cidx_r + 2'd1;
          if (cidx_r == 2'd3) begin
            if (left_nxt == '0) begin
              res[0].kind = KIND_END;
              res_n       = 2'd1;
              phase_nxt   = PH_IDLE;
            end else begin
              for (int c = 0; c < SENSOR_CHANNELS; c++) begin
                gt_new[c] = (cnt_nxt[c] != 4'd0);
              end
              sel       = pick_from(gt_new, 4'd0);
              cur_nxt   = sel[3] ? 3'd0 : sel[2:0];
              round_nxt = '0;
              odd_nxt   = 1'b0;
              phase_nxt = PH_HOLD;
            end
          end
        end
        PH_HOLD: begin
          held_nxt  = b;
          phase_nxt = PH_EMIT;
        end
        PH_EMIT: begin
          // Two samples share three bytes: the middle byte splits by nibble.
          res[0].kind         = KIND_SAMPLE;
          res[0].channel      = cur_r;
          res[0].sample_index = round_r;
          if (!odd_r) begin
            res[0].value = {b[7:4], held_r};
            held_nxt     = b;
            odd_nxt      = 1'b1;
          end else begin
            res[0].value = {held_r[3:0], b};
            odd_nxt      = 1'b0;
            phase_nxt    = PH_HOLD;
          end
          res_n    = 2'd1;
          left_dec = (left_r != '0) ? left_r - 7'd1 : left_r;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            res[1].kind = KIND_END;
            res_n       = 2'd2;
            phase_nxt   = PH_IDLE;
          end else begin
            sel = pick_from(gt_cur, {1'b0, cur_r} + 4'd1);
            if (!sel[3]) begin
              cur_nxt = sel[2:0];
            end else begin
              round_nxt = round_p1;
              sel       = pick_from(gt_next, 4'd0);
              cur_nxt   = sel[3] ? 3'd0 : sel[2:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (res_n == 2'd1) begin
      res[0].last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign push_n = fire ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mask_r  <= '0;
      cidx_r  <= '0;
      left_r  <= '0;
      cur_r   <= '0;
      round_r <= '0;
      odd_r   <= 1'b0;
      held_r  <= '0;
      prev_r  <= '0;
      seqv_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      cidx_r  <= cidx_nxt;
      left_r  <= left_nxt;
      cur_r   <= cur_nxt;
      round_r <= round_nxt;
      odd_r   <= odd_nxt;
      held_r  <= held_nxt;
      prev_r  <= prev_nxt;
      seqv_r  <= seqv_nxt;
    end
  end

  // The channel counts are only read once all four count bytes are in.
  always_ff @(posedge clk) begin
    if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  spd_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (res),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {2'b00, q_data.ratiometric, q_data.overcurrent, q_data.packet_lost,
                      q_data.sample_index, q_data.value, q_data.channel};
  assign out_tuser = q_data.kind;
  assign out_tlast = q_data.last;

  // While samples are being unpacked, at least one sample is still owed.
  a_samples_owed: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_HOLD) || (phase_r == PH_EMIT)) |-> (left_r != '0))
    else $error("sample phase entered with no samples left");

  // Overrun bytes are only expected while a mask bit remains.
  a_ovr_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OVR) |-> (mask_r != '0))
    else $error("overrun phase with an empty mask");

  // A processed header always leads to the digital input byte.
  a_header_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_sop_r) |=> (phase_r == PH_DIN))
    else $error("header did not restart the parser");

  // A byte is only consumed when the queue can take both of its results.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room2)
    else $error("results pushed into a full queue");

endmodule

### rtl/core/spd_res_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
module spd_res_fifo
  import spd_pkg::*;
#(
  parameter int DEPTH = RES_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  result_t    push_data [2],
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data[0];
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_data[1];
    end
  end

endmodule

### test/tb_sensor_packet_deframer.sv
// Self-checking testbench for the sensor packet deframer: byte stimulus, result prediction, checks.
module tb_sensor_packet_deframer;
  import spd_pkg::*;

  // Clock period, the extra wait after the last expected result has left the
  // block, the length of the deliberate output stall and the overall limit.
  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_STALL   = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTED  = 100;

  // One result as the block should deliver it, unpacked into its fields.
  typedef struct {
    kind_t       kind;
    logic [2:0]  channel;
    logic [11:0] value;
    logic [3:0]  sample_index;
    logic        packet_lost;
    logic        overcurrent;
    logic        ratiometric;
    logic        last;
  } deframed_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  sensor_packet_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Results still owed by the block, oldest first.
  deframed_t awaited_results[$];

  int mismatches     = 0;
  int bytes_consumed = 0;

  // Idling rates in percent of cycles, changed between the test phases.
  int in_gap_pct   = 0;
  int out_hold_pct = 0;

  // A long output stall is asked for by bumping the first counter; the
  // receiver process serves it and bumps the second.
  int long_stalls_asked = 0;
  int long_stalls_done  = 0;

  // The generator's idea of the next sequence number, so that most packets
  // arrive in order and only a few show up as lost.
  logic [1:0] gen_seq = 2'd0;

  // Shadow copy of the parser state, updated once per accepted input beat.
  phase_t     pstate       = PH_IDLE;
  logic [3:0] ovr_mask     = 4'd0;
  logic [1:0] cnt_idx      = 2'd0;
  logic [3:0] ch_count [SENSOR_CHANNELS] = '{default: 4'd0};
  logic [6:0] samples_due  = 7'd0;
  logic [2:0] cur_ch       = 3'd0;
  logic [3:0] cur_round    = 4'd0;
  logic       second_half  = 1'b0;
  logic [7:0] hold_byte    = 8'd0;
  logic [1:0] last_seq     = 2'd0;
  logic       seq_seen     = 1'b0;

  // -------------------------------------------------------------------------
  // Clock, limit
  // -------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // A run that has not finished by now is stuck: either the block has stopped
  // handing out results or it has lost some of them.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("sensor_packet_deframer verification failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic deframed_t blank_result(kind_t k);
    deframed_t r;
    r.kind         = k;
    r.channel      = 3'd0;
    r.value        = 12'd0;
    r.sample_index = 4'd0;
    r.packet_lost  = 1'b0;
    r.overcurrent  = 1'b0;
    r.ratiometric  = 1'b0;
    r.last         = 1'b0;
    return r;
  endfunction

  // Lowest channel at or above 'from' that still has a sample in 'round';
  // SENSOR_CHANNELS when none is left.
  function automatic int next_busy(int from, logic [3:0] round);
    for (int c = from; c < SENSOR_CHANNELS; c++) begin
      if (ch_count[c] > round) return c;
    end
    return SENSOR_CHANNELS;
  endfunction

  // Works out what one accepted byte makes the block emit and queues it.
  // Returns 1 when the byte is simply ignored (no packet in progress).
  function automatic bit deframe_byte(logic [7:0] b, logic sop);
    deframed_t batch[$];
    deframed_t e;
    int        k;
    int        c;
    logic [11:0] val;
    bit        ignored;
    ignored = 1'b0;
    if (sop) begin
      // A header always restarts the parser, even in the middle of a packet.
      e = blank_result(KIND_STATUS);
      e.packet_lost = seq_seen && (2'(last_seq + 2'd1) != b[7:6]);
      e.overcurrent = b[5];
      e.ratiometric = b[4];
      batch.push_back(e);
      last_seq    = b[7:6];
      seq_seen    = 1'b1;
      ovr_mask    = b[3:0];
      cnt_idx     = 2'd0;
      samples_due = 7'd0;
      cur_ch      = 3'd0;
      cur_round   = 4'd0;
      second_half = 1'b0;
      pstate      = PH_DIN;
    end else begin
      case (pstate)
        PH_DIN: begin
          e = blank_result(KIND_DIN);
          e.value = {4'd0, ~b};
          batch.push_back(e);
          pstate = PH_DOUT;
        end
        PH_DOUT: begin
          e = blank_result(KIND_ECHO);
          e.value = {4'd0, b};
          batch.push_back(e);
          pstate = (ovr_mask != 4'd0) ? PH_OVR : PH_CNT;
        end
        PH_OVR: begin
          // Overrun bytes are consumed lowest mask bit first.
          k = 0;
          while (k < 3 && !ovr_mask[k]) k++;
          e = blank_result(KIND_OVERRUN);
          e.channel = 3'(2 * k);
          e.value   = {8'd0, b[7:4]};
          batch.push_back(e);
          e.channel = 3'(2 * k + 1);
          e.value   = {8'd0, b[3:0]};
          batch.push_back(e);
          ovr_mask[k] = 1'b0;
          if (ovr_mask == 4'd0) pstate = PH_CNT;
        end
        PH_CNT: begin
          ch_count[2 * cnt_idx]     = b[7:4];
          ch_count[2 * cnt_idx + 1] = b[3:0];
          samples_due = samples_due + 7'(b[7:4]) + 7'(b[3:0]);
          if (cnt_idx == 2'd3) begin
            if (samples_due == 7'd0) begin
              batch.push_back(blank_result(KIND_END));
              pstate = PH_IDLE;
            end else begin
              cur_round   = 4'd0;
              c           = next_busy(0, cur_round);
              cur_ch      = (c < SENSOR_CHANNELS) ? 3'(c) : 3'd0;
              second_half = 1'b0;
              pstate      = PH_HOLD;
            end
          end
          cnt_idx = cnt_idx + 2'd1;
        end
        PH_HOLD: begin
          hold_byte = b;
          pstate    = PH_EMIT;
        end
        PH_EMIT: begin
          // Two samples share three bytes: the middle byte gives its high
          // nibble to the first sample and its low nibble to the second.
          if (!second_half) begin
            val         = {b[7:4], hold_byte};
            hold_byte   = b;
            second_half = 1'b1;
          end else begin
            val         = {hold_byte[3:0], b};
            second_half = 1'b0;
            pstate      = PH_HOLD;
          end
          e = blank_result(KIND_SAMPLE);
          e.channel      = cur_ch;
          e.value        = val;
          e.sample_index = cur_round;
          batch.push_back(e);
          if (samples_due != 7'd0) samples_due = samples_due - 7'd1;
          if (samples_due == 7'd0) begin
            batch.push_back(blank_result(KIND_END));
            pstate = PH_IDLE;
          end else begin
            c = next_busy(int'(cur_ch) + 1, cur_round);
            if (c < SENSOR_CHANNELS) begin
              cur_ch = 3'(c);
            end else begin
              cur_round = cur_round + 4'd1;
              c         = next_busy(0, cur_round);
              cur_ch    = (c < SENSOR_CHANNELS) ? 3'(c) : 3'd0;
            end
          end
        end
        default: begin
          ignored = 1'b1;
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
    return ignored;
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  // Only the first lines are printed so that a badly broken block cannot
  // flood the log; every mismatch is still counted.
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Every result beat is compared with the oldest expectation. Sampling at
  // the rising edge sees the values from before that edge's updates.
  always @(posedge clk) begin : result_check
    deframed_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, kind %0d tdata 0x%0h",
                                  out_tuser, out_tdata));
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", out_tuser, want.kind);
        check_field("channel", out_tdata[2:0], want.channel);
        check_field("value", out_tdata[14:3], want.value);
        check_field("sample_index", out_tdata[18:15], want.sample_index);
        check_field("packet_lost", out_tdata[19], want.packet_lost);
        check_field("overcurrent", out_tdata[20], want.overcurrent);
        check_field("ratiometric", out_tdata[21], want.ratiometric);
        check_field("tdata padding", out_tdata[23:22], 12'd0);
        check_field("last", out_tlast, want.last);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver
  // -------------------------------------------------------------------------

  // Drives out_tready at the falling edge. A requested long stall holds it
  // low for a counted stretch; otherwise it idles at the current rate.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stalls_asked != long_stalls_done) begin
        stall_left = LONG_STALL;
        long_stalls_done++;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= out_hold_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------

  // Presents one byte from a falling edge and holds it until accepted. It
  // returns at a falling edge: either straight after the accepting edge, so
  // the next call drives the next beat in the same step, or after an idle
  // gap with tvalid already low.
  task automatic send_byte(input logic [7:0] data, input logic sop);
    in_tdata  <= data;
    in_tuser  <= sop;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (!deframe_byte(data, sop)) bytes_consumed++;
    @(negedge clk);
    if ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_gap_pct);
    end
  endtask

  // Takes tvalid down before the sender goes quiet for a while.
  task automatic release_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Builds one packet with random content and sends it. Most packets are
  // whole and carry a few samples; some are cut short by the next header,
  // some are followed by stray bytes, some carry many or no samples.
  // With full_counts set, every channel carries the largest sample count.
  task automatic send_random_packet(input bit full_counts);
    logic [8:0] beats[$];
    logic [7:0] hdr;
    logic [3:0] cnt [SENSOR_CHANNELS];
    int         mode;
    int         total;
    int         nbytes;
    int         cut;
    mode  = $urandom_range(99);
    total = 0;
    hdr   = 8'($urandom);
    if ($urandom_range(9) != 0) hdr[7:6] = gen_seq;
    gen_seq = hdr[7:6] + 2'd1;
    beats.push_back({1'b1, hdr});
    beats.push_back({1'b0, 8'($urandom)});
    beats.push_back({1'b0, 8'($urandom)});
    for (int i = 0; i < 4; i++) begin
      if (hdr[i]) beats.push_back({1'b0, 8'($urandom)});
    end
    for (int c = 0; c < SENSOR_CHANNELS; c++) begin
      if (full_counts) cnt[c] = 4'd15;
      else if (mode < 10) cnt[c] = 4'd0;
      else if (mode < 13) cnt[c] = 4'($urandom_range(15));
      else cnt[c] = 4'($urandom_range(2));
      total += cnt[c];
    end
    for (int i = 0; i < 4; i++) beats.push_back({1'b0, cnt[2 * i], cnt[2 * i + 1]});
    // Three bytes for each pair of samples, two for an odd one at the end.
    nbytes = (total / 2) * 3 + (total % 2) * 2;
    for (int i = 0; i < nbytes; i++) beats.push_back({1'b0, 8'($urandom)});
    if (!full_counts && $urandom_range(9) == 0) begin
      cut = $urandom_range(beats.size() - 1, 1);
      while (beats.size() > cut) void'(beats.pop_back());
    end
    if (!full_counts && $urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) beats.push_back({1'b0, 8'($urandom)});
    end
    foreach (beats[i]) send_byte(beats[i][7:0], beats[i][8]);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Bytes before any header must be dropped without a result.
  task automatic test_bytes_before_header();
    send_byte(8'h5A, 1'b0);
  endtask

  // Hand-picked packets: every flag and every overrun slot set with extreme
  // counts, no samples at all, a lost sequence number, an odd sample count
  // with its unused nibble, a stray byte after the end and a packet that is
  // cut short by the next header.
  task automatic test_directed_packets();
    // First packet ever: never counted as lost; all four overrun bytes.
    send_byte(8'h3F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // All counts zero, so the last count byte closes the packet.
    repeat (4) send_byte(8'h00, 1'b0);
    // Sequence jumps from 0 to 3, so the packet is flagged as lost.
    send_byte(8'hC0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // One sample on channel 0, two on channel 7: three samples in all.
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Odd sample: the low nibble of the last byte goes unused.
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    // A stray byte after the end is ignored.
    send_byte(8'h77, 1'b0);
    // A packet dropped mid-way; the next header takes over.
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    gen_seq = 2'd1;
  endtask

  task automatic test_random_packets(input int n);
    int target;
    target = bytes_consumed + n;
    while (bytes_consumed < target) send_random_packet(1'b0);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering
  // a packet with the most samples, so the result queue fills and the input
  // has to stall too. The same packet reaches sample index 14, the highest its counts allow.
  task automatic test_output_backpressure();
    long_stalls_asked++;
    send_random_packet(1'b1);
  endtask

  // -------------------------------------------------------------------------
  // Sequence of the run
  // -------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tuser  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Sender rarely idles, receiver mostly stalls.
    in_gap_pct   = 8;
    out_hold_pct = 88;
    test_bytes_before_header();
    test_directed_packets();
    test_random_packets(360);

    // Sender mostly idles, receiver rarely stalls.
    in_gap_pct   = 88;
    out_hold_pct = 8;
    test_random_packets(360);

    // Neither side idles.
    in_gap_pct   = 0;
    out_hold_pct = 0;
    test_output_backpressure();
    test_random_packets(360);

    // Let the block hand out everything it still owes, then keep watching for
    // DRAIN_CYCLES more so that any surplus beat would be caught.
    release_input();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sensor_packet_deframer verification clean");
    end else begin
      $display("sensor_packet_deframer verification failed");
    end
    $finish;
  end

endmodule
